// ===== design/msa_pkg.sv =====
package msa_pkg;

    // command codes of an input item
    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_SPLAT = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_code_t;

    // one stored cell: field, heat, depth
    localparam int VAL_W  = 16;
    localparam int CELL_W = 3 * VAL_W;
    localparam logic [VAL_W-1:0] VAL_MAX = 16'hFFFF;
    localparam logic [CELL_W-1:0] CELL_EMPTY = {16'h0000, 16'h0000, 16'hFFFF};

    // reciprocal numerator 255 * 65536 and divider width
    localparam logic [24:0] RECIP_NUM = 25'd16711680;
    localparam int DIV_W = 25;
    localparam int MUL_W = 23;
    localparam int MUL_LO_W = 12;

    // x * 4 / 5 as (x * 4 * 3277) >> 14, exact below 16384
    localparam logic [11:0] FIFTH_MUL = 12'd3277;
    localparam int FIFTH_SHIFT = 14;

    // x / 255 as (x * 32897) >> 23, exact below 66052
    localparam logic [15:0] HEAT_BIAS = 16'd127;
    localparam logic [16:0] INV255_MUL = 17'd32897;
    localparam int INV255_SHIFT = 23;

    // sphere front-surface rom
    localparam longint ROM_SCALE = 64'd16842495;
    typedef logic [VAL_W-1:0] rom_t [256];

    function automatic rom_t build_sphere_rom();
        rom_t   rom;
        longint n;
        longint s;
        longint t;
        for (int i = 0; i < 256; i++)
        begin
            n = ROM_SCALE * longint'(255 - i);
            s = 0;
            for (int b = 16; b >= 0; b--)
            begin
                t = s | (longint'(1) << b);
                if (t * t <= n)
                begin
                    s = t;
                end
            end
            if (n > s * s + s)
            begin
                s = s + 1;
            end
            rom[i] = s[VAL_W-1:0];
        end
        return rom;
    endfunction

    localparam rom_t SPHERE_ROM = build_sphere_rom();

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic setup;
        logic setup2;
        logic div_init;
        logic div_step;
        logic data_latch;
        logic cell_write;
        logic clr_step;
        logic rd_issue;
        logic res_load;
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic box_empty;
        logic div_last;
        logic x_last;
        logic y_last;
        logic clr_last;
    } dp_status_t;

endpackage

// ===== design/msa_if.sv =====
interface msa_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic signed [10:0] center_x;
    logic signed [10:0] center_y;
    logic [7:0]  pixel_radius;
    logic [15:0] center_depth;
    logic [15:0] sphere_depth_radius;
    logic [7:0]  speed_index;
    logic [13:0] cell_address;

    modport source (
        output valid, command, center_x, center_y, pixel_radius, center_depth,
               sphere_depth_radius, speed_index, cell_address,
        input  ready
    );
    modport sink (
        input  valid, command, center_x, center_y, pixel_radius, center_depth,
               sphere_depth_radius, speed_index, cell_address,
        output ready
    );
endinterface

interface msa_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] cell_field;
    logic [15:0] cell_heat;
    logic [15:0] cell_depth;

    modport source (
        output valid, cell_field, cell_heat, cell_depth,
        input  ready
    );
    modport sink (
        input  valid, cell_field, cell_heat, cell_depth,
        output ready
    );
endinterface

// ===== design/msa_ram.sv =====
module msa_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 14400
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== design/msa_ctrl.sv =====
module msa_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [1:0]          in_command,
    output logic                in_ready,
    input  logic                out_ready,
    output logic                out_valid,
    input  msa_pkg::dp_status_t status,
    output msa_pkg::dp_cmd_t    cmd
);
    typedef enum logic [4:0] {
        S_INIT_CLEAR,
        S_IDLE,
        S_CLEAR,
        S_SETUP,
        S_SETUP2,
        S_DIV_INIT,
        S_DIV,
        S_C0,
        S_C1,
        S_C2,
        S_C3,
        S_C4,
        S_C5,
        S_C6,
        S_READ,
        S_READ_LATCH,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign accept    = in_valid && in_ready;

    // command decode and next state
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_INIT_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (status.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load = 1'b1;
                    unique case (msa_pkg::cmd_code_t'(in_command))
                        msa_pkg::CMD_CLEAR: state_next = S_CLEAR;
                        msa_pkg::CMD_SPLAT: state_next = S_SETUP;
                        msa_pkg::CMD_READ:  state_next = S_READ;
                        default:            state_next = S_FINISH;
                    endcase
                end
            end
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (status.clr_last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = S_SETUP2;
            end
            S_SETUP2:
            begin
                cmd.setup2 = 1'b1;
                state_next = S_DIV_INIT;
            end
            S_DIV_INIT:
            begin
                if (status.box_empty)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.div_init = 1'b1;
                    state_next   = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = S_C0;
                end
            end
            S_C0: state_next = S_C1;
            S_C1:
            begin
                cmd.data_latch = 1'b1;
                state_next     = S_C2;
            end
            S_C2: state_next = S_C3;
            S_C3: state_next = S_C4;
            S_C4: state_next = S_C5;
            S_C5: state_next = S_C6;
            S_C6:
            begin
                cmd.cell_write = 1'b1;
                if (status.x_last && status.y_last)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_C0;
                end
            end
            S_READ:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = S_READ_LATCH;
            end
            S_READ_LATCH:
            begin
                cmd.data_latch = 1'b1;
                state_next     = S_FINISH;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // output valid follows result loads and takes
    always_comb
    begin
        if (cmd.res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule

// ===== design/msa_datapath.sv =====
module msa_datapath #(
    parameter int GRID_WIDTH       = 120,
    parameter int GRID_HEIGHT      = 120,
    parameter int MAX_PIXEL_RADIUS = 255
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  msa_pkg::dp_cmd_t     cmd,
    output msa_pkg::dp_status_t  status,
    input  logic [1:0]           in_command,
    input  logic signed [10:0]   in_center_x,
    input  logic signed [10:0]   in_center_y,
    input  logic [7:0]           in_pixel_radius,
    input  logic [15:0]          in_center_depth,
    input  logic [15:0]          in_sphere_depth_radius,
    input  logic [7:0]           in_speed_index,
    input  logic [13:0]          in_cell_address,
    output logic [15:0]          cell_field,
    output logic [15:0]          cell_heat,
    output logic [15:0]          cell_depth
);
    localparam int CELLS  = GRID_WIDTH * GRID_HEIGHT;
    localparam int AW     = $clog2(CELLS);
    localparam int XW     = $clog2(GRID_WIDTH);
    localparam int YW     = $clog2(GRID_HEIGHT);
    localparam int RMAX   = (MAX_PIXEL_RADIUS * 4 / 5 > 2) ? MAX_PIXEL_RADIUS * 4 / 5 : 2;
    localparam int RADW   = $clog2(RMAX + 1);
    localparam int R2W    = 2 * RADW;
    localparam int D2W    = R2W + 1;
    localparam int CW     = $clog2(RMAX + GRID_WIDTH + GRID_HEIGHT + 1024) + 2;
    localparam int SUMW   = D2W + msa_pkg::MUL_W + 1;
    localparam int CNTW   = $clog2(msa_pkg::DIV_W + 1);
    localparam int VW     = msa_pkg::VAL_W;
    localparam int MUL_LO_W = msa_pkg::MUL_LO_W;

    // latched item
    logic [1:0]         cmd_reg;
    logic signed [10:0] cxin_reg;
    logic signed [10:0] cyin_reg;
    logic [7:0]         prad_reg;
    logic [VW-1:0]      zc_reg;
    logic [VW-1:0]      rw_reg;
    logic [7:0]         speed_reg;
    logic [13:0]        addr_reg;
    logic               in_range_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg      <= in_command;
            cxin_reg     <= in_center_x;
            cyin_reg     <= in_center_y;
            prad_reg     <= in_pixel_radius;
            zc_reg       <= in_center_depth;
            rw_reg       <= in_sphere_depth_radius;
            speed_reg    <= in_speed_index;
            addr_reg     <= in_cell_address;
            in_range_reg <= (int'(in_cell_address) < CELLS);
        end
    end

    // setup: halved centre and support radius
    logic signed [10:0] cx_half;
    logic signed [10:0] cy_half;
    logic [10:0]        pr_cap;
    logic [11:0]        pr4;
    logic [23:0]        fifth_prod;
    logic [RADW-1:0]    rad_raw;
    logic signed [CW-1:0] cx_reg;
    logic signed [CW-1:0] cy_reg;
    logic [RADW-1:0]    radius_reg;

    assign cx_half = (cxin_reg + signed'(11'(cxin_reg[10]))) >>> 1;
    assign cy_half = (cyin_reg + signed'(11'(cyin_reg[10]))) >>> 1;
    assign pr_cap  = ({3'b000, prad_reg} > 11'(MAX_PIXEL_RADIUS)) ?
                     11'(MAX_PIXEL_RADIUS) : {3'b000, prad_reg};
    assign pr4        = {pr_cap[9:0], 2'b00};
    assign fifth_prod = pr4 * msa_pkg::FIFTH_MUL;
    assign rad_raw    = fifth_prod[msa_pkg::FIFTH_SHIFT +: RADW];

    always_ff @(posedge clk)
    begin
        if (cmd.setup)
        begin
            cx_reg     <= CW'(cx_half);
            cy_reg     <= CW'(cy_half);
            radius_reg <= (rad_raw < RADW'(2)) ? RADW'(2) : rad_raw;
        end
    end

    // setup2: clipped box and squared radius
    logic signed [CW-1:0] rad_s;
    logic signed [CW-1:0] lo_x;
    logic signed [CW-1:0] hi_x;
    logic signed [CW-1:0] lo_y;
    logic signed [CW-1:0] hi_y;
    logic signed [CW-1:0] x0_reg;
    logic signed [CW-1:0] x1_reg;
    logic signed [CW-1:0] y0_reg;
    logic signed [CW-1:0] y1_reg;
    logic [R2W-1:0]       r2_reg;

    assign rad_s = signed'(CW'(radius_reg));
    assign lo_x  = cx_reg - rad_s;
    assign hi_x  = cx_reg + rad_s;
    assign lo_y  = cy_reg - rad_s;
    assign hi_y  = cy_reg + rad_s;

    always_ff @(posedge clk)
    begin
        if (cmd.setup2)
        begin
            x0_reg <= (lo_x < 0) ? '0 : lo_x;
            x1_reg <= (hi_x > CW'(GRID_WIDTH - 1)) ? CW'(GRID_WIDTH - 1) : hi_x;
            y0_reg <= (lo_y < 0) ? '0 : lo_y;
            y1_reg <= (hi_y > CW'(GRID_HEIGHT - 1)) ? CW'(GRID_HEIGHT - 1) : hi_y;
            r2_reg <= radius_reg * radius_reg;
        end
    end

    assign status.box_empty = (x0_reg > x1_reg) || (y0_reg > y1_reg);

    // restoring divider for the reciprocal, one quotient bit a cycle
    logic [msa_pkg::DIV_W-1:0] div_n_reg;
    logic [msa_pkg::DIV_W-1:0] div_q_reg;
    logic [R2W:0]              div_rem_reg;
    logic [CNTW-1:0]           div_cnt_reg;
    logic [R2W:0]              div_trial;
    logic                      div_ge;

    assign div_trial = {div_rem_reg[R2W-1:0], div_n_reg[msa_pkg::DIV_W-1]};
    assign div_ge    = (div_trial >= {1'b0, r2_reg});
    assign status.div_last = (div_cnt_reg == CNTW'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg <= '0;
        end
        else if (cmd.div_init)
        begin
            div_cnt_reg <= CNTW'(msa_pkg::DIV_W);
        end
        else if (cmd.div_step)
        begin
            div_cnt_reg <= div_cnt_reg - CNTW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_init)
        begin
            div_n_reg   <= msa_pkg::RECIP_NUM + msa_pkg::DIV_W'(r2_reg >> 1);
            div_q_reg   <= '0;
            div_rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            div_n_reg   <= {div_n_reg[msa_pkg::DIV_W-2:0], 1'b0};
            div_q_reg   <= {div_q_reg[msa_pkg::DIV_W-2:0], div_ge};
            div_rem_reg <= div_ge ? (div_trial - {1'b0, r2_reg}) : div_trial;
        end
    end

    // box walk
    logic signed [CW-1:0] x_reg;
    logic signed [CW-1:0] y_reg;
    logic [AW-1:0]        row_base_reg;
    logic [AW-1:0]        cell_addr;

    assign status.x_last = (x_reg == x1_reg);
    assign status.y_last = (y_reg == y1_reg);
    assign cell_addr     = row_base_reg + AW'(x_reg[XW-1:0]);

    always_ff @(posedge clk)
    begin
        if (cmd.div_init)
        begin
            x_reg        <= x0_reg;
            y_reg        <= y0_reg;
            row_base_reg <= AW'(y0_reg[YW-1:0] * AW'(GRID_WIDTH));
        end
        else if (cmd.cell_write)
        begin
            if (status.x_last)
            begin
                x_reg        <= x0_reg;
                y_reg        <= y_reg + CW'(1);
                row_base_reg <= row_base_reg + AW'(GRID_WIDTH);
            end
            else
            begin
                x_reg <= x_reg + CW'(1);
            end
        end
    end

    // clearing sweep counter
    logic [AW-1:0] clr_cnt_reg;

    assign status.clr_last = (clr_cnt_reg == AW'(CELLS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.load)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clr_step)
        begin
            clr_cnt_reg <= status.clr_last ? '0 : clr_cnt_reg + AW'(1);
        end
    end

    // cell store
    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [msa_pkg::CELL_W-1:0]  ram_wdata;
    logic [AW-1:0]               ram_raddr;
    logic [msa_pkg::CELL_W-1:0]  ram_rdata;
    logic [msa_pkg::CELL_W-1:0]  cell_wdata;
    logic                        cell_hit;

    assign ram_raddr = cmd.rd_issue ? AW'(addr_reg) : cell_addr;
    assign ram_we    = cmd.clr_step || (cmd.cell_write && cell_hit);
    assign ram_waddr = cmd.clr_step ? clr_cnt_reg : cell_addr;
    assign ram_wdata = cmd.clr_step ? msa_pkg::CELL_EMPTY : cell_wdata;

    msa_ram #(
        .WIDTH (msa_pkg::CELL_W),
        .DEPTH (CELLS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    logic [msa_pkg::CELL_W-1:0] data_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.data_latch)
        begin
            data_reg <= ram_rdata;
        end
    end

    // per-cell pipeline, stable over the seven phases of one cell
    logic signed [CW-1:0]     dx;
    logic signed [CW-1:0]     dy;
    logic signed [2*CW-1:0]   dx_sq;
    logic signed [2*CW-1:0]   dy_sq;
    logic [D2W-1:0]           d2_reg;
    logic [D2W+MUL_LO_W-1:0]  plo_reg;
    logic [D2W+msa_pkg::MUL_W-MUL_LO_W-1:0] phi_reg;
    logic [SUMW-1:0]          prod_sum;
    logic [7:0]               idx_reg;
    logic                     idx_ok_reg;
    logic [7:0]               f_val;
    logic [15:0]              f_sq;
    logic [7:0]               w_reg;
    logic [VW-1:0]            rom_reg;
    logic [15:0]              heat_num_reg;
    logic [2*VW-1:0]          dp_prod;
    logic [VW-1:0]            dp_reg;
    logic [32:0]              inc_prod;
    logic [7:0]               inc_reg;
    logic [VW:0]              surf_diff;
    logic [VW-1:0]            surf_reg;
    logic [VW:0]              field_sum;
    logic [VW:0]              heat_sum;
    logic [VW-1:0]            old_field;
    logic [VW-1:0]            old_heat;
    logic [VW-1:0]            old_depth;

    assign dx       = x_reg - cx_reg;
    assign dy       = y_reg - cy_reg;
    assign dx_sq    = dx * dx;
    assign dy_sq    = dy * dy;
    assign prod_sum = SUMW'(plo_reg) + (SUMW'(phi_reg) << MUL_LO_W);
    assign f_val    = 8'd255 - idx_reg;
    assign f_sq     = f_val * f_val;
    assign dp_prod  = rw_reg * rom_reg;
    assign inc_prod = heat_num_reg * msa_pkg::INV255_MUL;
    assign surf_diff = {1'b0, zc_reg} - {1'b0, dp_reg};

    always_ff @(posedge clk)
    begin
        d2_reg       <= D2W'(dx_sq[R2W-1:0]) + D2W'(dy_sq[R2W-1:0]);
        plo_reg      <= d2_reg * div_q_reg[MUL_LO_W-1:0];
        phi_reg      <= d2_reg * div_q_reg[msa_pkg::MUL_W-1:MUL_LO_W];
        idx_reg      <= prod_sum[23:16];
        idx_ok_reg   <= (prod_sum[SUMW-1:24] == '0);
        w_reg        <= f_sq[15:8];
        rom_reg      <= msa_pkg::SPHERE_ROM[idx_reg];
        heat_num_reg <= w_reg * speed_reg + msa_pkg::HEAT_BIAS;
        dp_reg       <= dp_prod[2*VW-1:VW];
        inc_reg      <= inc_prod[msa_pkg::INV255_SHIFT +: 8];
        surf_reg     <= surf_diff[VW] ? '0 : surf_diff[VW-1:0];
    end

    // update of the cell: saturating field and heat sums, nearest depth kept
    assign old_field  = data_reg[3*VW-1:2*VW];
    assign old_heat   = data_reg[2*VW-1:VW];
    assign old_depth  = data_reg[VW-1:0];
    assign field_sum  = {1'b0, old_field} + (VW + 1)'(w_reg);
    assign heat_sum   = {1'b0, old_heat} + (VW + 1)'(inc_reg);
    assign cell_hit   = idx_ok_reg && (w_reg != 8'd0);
    assign cell_wdata = {field_sum[VW] ? msa_pkg::VAL_MAX : field_sum[VW-1:0],
                         heat_sum[VW] ? msa_pkg::VAL_MAX : heat_sum[VW-1:0],
                         (surf_reg < old_depth) ? surf_reg : old_depth};

    // result register
    logic [VW-1:0] res_field_reg;
    logic [VW-1:0] res_heat_reg;
    logic [VW-1:0] res_depth_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            if (cmd_reg == msa_pkg::CMD_READ && in_range_reg)
            begin
                res_field_reg <= old_field;
                res_heat_reg  <= old_heat;
                res_depth_reg <= old_depth;
            end
            else if (cmd_reg == msa_pkg::CMD_READ)
            begin
                res_field_reg <= '0;
                res_heat_reg  <= '0;
                res_depth_reg <= msa_pkg::VAL_MAX;
            end
            else
            begin
                res_field_reg <= '0;
                res_heat_reg  <= '0;
                res_depth_reg <= '0;
            end
        end
    end

    assign cell_field = res_field_reg;
    assign cell_heat  = res_heat_reg;
    assign cell_depth = res_depth_reg;
endmodule

// ===== design/metaball_splat_accumulator_unit.sv =====
// Metaball splat accumulator: collects particle splats on a half-resolution
// grid whose cells hold field weight, heat and nearest depth.
// items: one input item per command (clear, splat, read, no operation),
// taken when valid and ready are both high. ready is high only while idle.
// results: exactly one result item per input item, in order. Only a read
// returns cell contents; every other command returns zeros.
// Splat: setup, then a bit-serial reciprocal divider, then a walk over the
// clipped box, one cell after another, since each cell does a read, multiply
// chain and write on the one-read one-write cell memory.
// At reset the cell memory is swept, one cell a cycle, with ready low; no
// result item comes from that sweep.
// The result sits in an output register; the next item is accepted while it
// waits, and that item's result is held back until the receiver takes the
// earlier one.
module metaball_splat_accumulator_unit #(
    parameter int GRID_WIDTH       = 120,
    parameter int GRID_HEIGHT      = 120,
    parameter int MAX_PIXEL_RADIUS = 255
) (
    input  logic      clk,
    input  logic      rst_n,
    msa_in_if.sink    items,
    msa_out_if.source results
);
    msa_pkg::dp_cmd_t    cmd;
    msa_pkg::dp_status_t status;

    msa_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (items.valid),
        .in_command (items.command),
        .in_ready   (items.ready),
        .out_ready  (results.ready),
        .out_valid  (results.valid),
        .status     (status),
        .cmd        (cmd)
    );

    msa_datapath #(
        .GRID_WIDTH       (GRID_WIDTH),
        .GRID_HEIGHT      (GRID_HEIGHT),
        .MAX_PIXEL_RADIUS (MAX_PIXEL_RADIUS)
    ) u_datapath (
        .clk                    (clk),
        .rst_n                  (rst_n),
        .cmd                    (cmd),
        .status                 (status),
        .in_command             (items.command),
        .in_center_x            (items.center_x),
        .in_center_y            (items.center_y),
        .in_pixel_radius        (items.pixel_radius),
        .in_center_depth        (items.center_depth),
        .in_sphere_depth_radius (items.sphere_depth_radius),
        .in_speed_index         (items.speed_index),
        .in_cell_address        (items.cell_address),
        .cell_field             (results.cell_field),
        .cell_heat              (results.cell_heat),
        .cell_depth             (results.cell_depth)
    );
endmodule

// ===== sim/metaball_splat_accumulator_unit_checker.sv =====
module metaball_splat_accumulator_unit_checker (
    input  logic      clk,
    input  logic      rst_n,
    msa_in_if.sink    items,
    msa_out_if.sink   results,
    output int        fail_count,
    output int        pending_reads
);

    localparam int GW = 120;
    localparam int GH = 120;
    localparam int CELLS = GW * GH;
    localparam int MAX_PR = 255;

    typedef struct packed {
        logic [15:0] field;
        logic [15:0] heat;
        logic [15:0] depth;
    } cell_t;

    logic [15:0] field_grid [CELLS];
    logic [15:0] heat_grid  [CELLS];
    logic [15:0] depth_grid [CELLS];
    logic [15:0] surf_rom   [256];
    cell_t       expected_cells [$];
    int          mismatch_count;

    // front-surface depth table, rounded integer square roots
    function automatic logic [15:0] rounded_root(longint n);
        longint s;
        longint t;
        s = 0;
        for (int b = 16; b >= 0; b--)
        begin
            t = s | (longint'(1) << b);
            if (t * t <= n)
            begin
                s = t;
            end
        end
        if (n > s * s + s)
        begin
            s = s + 1;
        end
        return s[15:0];
    endfunction

    task automatic wipe_grid();
        for (int i = 0; i < CELLS; i++)
        begin
            field_grid[i] = '0;
            heat_grid[i]  = '0;
            depth_grid[i] = 16'hFFFF;
        end
    endtask

    // accumulate one particle into the grid
    task automatic splat_particle(logic signed [10:0] px, logic signed [10:0] py,
                                  logic [7:0] prad, logic [15:0] zc,
                                  logic [15:0] rw, logic [7:0] spd);
        int     cx;
        int     cy;
        int     pr;
        int     rad;
        longint r2;
        longint mul;
        longint d2;
        longint idx;
        longint f;
        longint w;
        longint acc;
        longint surf;
        int     x0;
        int     x1;
        int     y0;
        int     y1;
        int     at;
        cx = int'(px) / 2;
        cy = int'(py) / 2;
        pr = int'(prad);
        if (pr > MAX_PR)
        begin
            pr = MAX_PR;
        end
        rad = pr * 4 / 5;
        if (rad < 2)
        begin
            rad = 2;
        end
        r2  = rad * rad;
        mul = (64'd16711680 + r2 / 2) / r2;
        x0 = (cx - rad < 0) ? 0 : cx - rad;
        x1 = (cx + rad > GW - 1) ? GW - 1 : cx + rad;
        y0 = (cy - rad < 0) ? 0 : cy - rad;
        y1 = (cy + rad > GH - 1) ? GH - 1 : cy + rad;
        for (int y = y0; y <= y1; y++)
        begin
            for (int x = x0; x <= x1; x++)
            begin
                d2  = longint'((x - cx) * (x - cx)) + longint'((y - cy) * (y - cy));
                idx = (d2 * mul) >> 16;
                if (idx < 256)
                begin
                    f = 255 - idx;
                    w = (f * f) >> 8;
                    if (w != 0)
                    begin
                        at  = y * GW + x;
                        acc = longint'(field_grid[at]) + w;
                        field_grid[at] = (acc > 65535) ? 16'hFFFF : acc[15:0];
                        acc = longint'(heat_grid[at]) + (w * longint'(spd) + 127) / 255;
                        heat_grid[at] = (acc > 65535) ? 16'hFFFF : acc[15:0];
                        surf = longint'(zc) - ((longint'(rw) * longint'(surf_rom[idx])) >> 16);
                        if (surf < 0)
                        begin
                            surf = 0;
                        end
                        if (surf < longint'(depth_grid[at]))
                        begin
                            depth_grid[at] = surf[15:0];
                        end
                    end
                end
            end
        end
    endtask

    initial
    begin
        for (int i = 0; i < 256; i++)
        begin
            surf_rom[i] = rounded_root(64'd16842495 * longint'(255 - i));
        end
        wipe_grid();
    end

    assign pending_reads = expected_cells.size();

    // predict on accepted items, compare on accepted results
    always @(posedge clk or negedge rst_n)
    begin
        cell_t got;
        cell_t exp_cell;
        int    addr;
        if (!rst_n)
        begin
            fail_count     <= 0;
            mismatch_count = 0;
        end
        else
        begin
            if (results.valid && results.ready)
            begin
                got = '{results.cell_field, results.cell_heat, results.cell_depth};
                if (expected_cells.size() == 0)
                begin
                    fail_count <= fail_count + 1;
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("unexpected result item %h", got);
                    end
                end
                else
                begin
                    exp_cell = expected_cells.pop_front();
                    if (got !== exp_cell)
                    begin
                        fail_count <= fail_count + 1;
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            $display("mismatch field exp %0d got %0d heat exp %0d got %0d",
                                     exp_cell.field, got.field, exp_cell.heat, got.heat);
                            $display("         depth exp %0d got %0d",
                                     exp_cell.depth, got.depth);
                        end
                    end
                end
            end
            if (items.valid && items.ready)
            begin
                exp_cell = '0;
                case (msa_pkg::cmd_code_t'(items.command))
                    msa_pkg::CMD_CLEAR: wipe_grid();
                    msa_pkg::CMD_SPLAT: splat_particle(items.center_x, items.center_y,
                                                       items.pixel_radius, items.center_depth,
                                                       items.sphere_depth_radius,
                                                       items.speed_index);
                    msa_pkg::CMD_READ:
                    begin
                        addr = int'(items.cell_address);
                        if (addr < CELLS)
                        begin
                            exp_cell = '{field_grid[addr], heat_grid[addr], depth_grid[addr]};
                        end
                        else
                        begin
                            exp_cell.depth = 16'hFFFF;
                        end
                    end
                    default: ;
                endcase
                expected_cells.push_back(exp_cell);
            end
        end
    end

endmodule

// ===== sim/metaball_splat_accumulator_unit_tb.sv =====
module metaball_splat_accumulator_unit_tb;

    localparam longint CYCLE_LIMIT = 64'd25000000;

    logic   clk;
    logic   rst_n;
    int     fail_count;
    int     pending_reads;
    int     send_idle_pct;
    int     recv_idle_pct;
    longint cycle_count;

    msa_in_if  items ();
    msa_out_if results ();

    metaball_splat_accumulator_unit u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items.sink),
        .results (results.source)
    );

    metaball_splat_accumulator_unit_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .items         (items.sink),
        .results       (results.sink),
        .fail_count    (fail_count),
        .pending_reads (pending_reads)
    );

    // clock and cycle limit
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("metaball_splat_accumulator_unit_tb failed");
            $finish;
        end
    end

    // receiver stalls
    always @(negedge clk)
    begin
        results.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // hand one item to the block, waiting for acceptance
    task automatic send_item(msa_pkg::cmd_code_t cmd, int px, int py, int prad,
                             int zc, int rw, int spd, int addr);
        while ($urandom_range(99) < send_idle_pct)
        begin
            items.valid <= 1'b0;
            @(negedge clk);
        end
        items.valid               <= 1'b1;
        items.command             <= cmd;
        items.center_x            <= px[10:0];
        items.center_y            <= py[10:0];
        items.pixel_radius        <= prad[7:0];
        items.center_depth        <= zc[15:0];
        items.sphere_depth_radius <= rw[15:0];
        items.speed_index         <= spd[7:0];
        items.cell_address        <= addr[13:0];
        @(posedge clk);
        while (!items.ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic send_read(int addr);
        send_item(msa_pkg::CMD_READ, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, addr);
    endtask

    // splats near the grid, few large; tiny ones anywhere; reads, clears
    task automatic send_random_item();
        int sel;
        int prad;
        sel = $urandom_range(99);
        if (sel < 2)
        begin
            send_item(msa_pkg::CMD_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom);
        end
        else if (sel < 5)
        begin
            send_item(msa_pkg::CMD_NOP, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom);
        end
        else if (sel < 50)
        begin
            prad = ($urandom_range(49) == 0) ? $urandom_range(255) : $urandom_range(12);
            send_item(msa_pkg::CMD_SPLAT, $urandom_range(280) - 20, $urandom_range(280) - 20,
                      prad, $urandom, $urandom, $urandom, $urandom);
        end
        else if (sel < 53)
        begin
            send_item(msa_pkg::CMD_SPLAT, $urandom_range(2047) - 1024,
                      $urandom_range(2047) - 1024, $urandom_range(8), $urandom, $urandom,
                      $urandom, $urandom);
        end
        else if (sel < 57)
        begin
            send_read($urandom_range(16383));
        end
        else
        begin
            send_read($urandom_range(14399));
        end
    endtask

    // stop sending and wait for every expected result
    task automatic wait_drained();
        items.valid <= 1'b0;
        while (pending_reads != 0)
        begin
            @(negedge clk);
        end
    endtask

    initial
    begin
        rst_n                     = 1'b0;
        cycle_count               = 0;
        send_idle_pct             = 0;
        recv_idle_pct             = 0;
        items.valid               = 1'b0;
        items.command             = msa_pkg::CMD_NOP;
        items.center_x            = '0;
        items.center_y            = '0;
        items.pixel_radius        = '0;
        items.center_depth        = '0;
        items.sphere_depth_radius = '0;
        items.speed_index         = '0;
        items.cell_address        = '0;
        results.ready             = 1'b0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // directed: empty reads, extremes, overlapping splats, saturation
        send_read(0);
        send_read(14399);
        send_read(16383);
        send_item(msa_pkg::CMD_SPLAT, 0, 0, 0, 65535, 65535, 255, 0);
        send_item(msa_pkg::CMD_SPLAT, -1, -1, 1, 0, 65535, 0, 0);
        send_item(msa_pkg::CMD_SPLAT, 239, 239, 7, 100, 0, 128, 0);
        send_item(msa_pkg::CMD_SPLAT, 767, 767, 200, 0, 0, 0, 0);
        send_item(msa_pkg::CMD_SPLAT, -512, -512, 255, 0, 0, 0, 0);
        send_item(msa_pkg::CMD_SPLAT, -1024, 1023, 3, 0, 0, 0, 0);
        send_item(msa_pkg::CMD_SPLAT, 120, 120, 255, 40000, 30000, 255, 0);
        for (int i = 0; i < 4; i++)
        begin
            send_item(msa_pkg::CMD_SPLAT, 21, 20, 12, 65535, 65535, 255, 0);
        end
        send_read(10 * 120 + 10);
        send_read(0);
        send_read(119 * 120 + 119);
        send_item(msa_pkg::CMD_NOP, 100, 100, 20, 0, 0, 255, 0);
        send_read(60 * 120 + 60);
        send_item(msa_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0);
        send_read(10 * 120 + 10);
        send_read(60 * 120 + 60);
        wait_drained();

        // random phases with different idling
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 14 : (phase == 1) ? 77 : 0;
            recv_idle_pct = (phase == 0) ? 77 : (phase == 1) ? 14 : 0;
            for (int n = 0; n < 650; n++)
            begin
                send_random_item();
                if (n == 300)
                begin
                    wait_drained();
                end
            end
        end

        wait_drained();
        repeat (40) @(negedge clk);
        if (fail_count == 0 && pending_reads == 0)
        begin
            $display("metaball_splat_accumulator_unit_tb passed");
        end
        else
        begin
            $display("metaball_splat_accumulator_unit_tb failed");
        end
        $finish;
    end

endmodule
